FILE: sv/lav_pkg.sv
// Package for the look-at view matrix core.
// Holds the widths and defaults of the block, used by lav_norm and the top module.
// No dependencies.
package lav_pkg;

    // Default number of fraction bits in the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    // Width of each input coordinate.
    localparam int IN_W = 32;

    // Width of each axis entry on the output.
    localparam int AX_W = 18;

    // Width of each translation entry on the output.
    localparam int TR_W = 32;

    // Working width of the normalizer datapath. It must be a power of two.
    localparam int NRM_W = 64;

    // Width of a normalized magnitude; its top bit lands on bit NRM_MW-1.
    localparam int NRM_MW = 31;

    // Width of the square root of a sum of three squared magnitudes.
    localparam int NRM_RW = 32;

endpackage

FILE: sv/lav_div.sv
// One lane of the pipelined restoring divider used by the normalizer.
// Produces one quotient bit per stage; QB stages in all.
// No package dependencies.
module lav_div #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QB = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_q
);

    logic [NW-1:0] r_rem [QB];
    logic [DW-1:0] r_den [QB];
    logic [QB-1:0] r_q   [QB];

    // Each stage tries the divisor at one bit weight, most significant first.
    for (genvar t = 0; t < QB; t++) begin : g_stage
        localparam int B = QB - 1 - t;
        logic [NW-1:0] w_rem;
        logic [DW-1:0] w_den;
        logic [QB-1:0] w_q;
        logic [NW:0]   w_sub;
        logic          w_ge;

        if (t == 0) begin : g_first
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_q   = '0;
        end else begin : g_next
            assign w_rem = r_rem[t-1];
            assign w_den = r_den[t-1];
            assign w_q   = r_q[t-1];
        end

        assign w_sub = (NW+1)'(w_den) << B;
        assign w_ge  = (NW+1)'(w_rem) >= w_sub;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[t] <= w_ge ? (w_rem - w_sub[NW-1:0]) : w_rem;
                r_den[t] <= w_den;
                r_q[t]   <= w_q | (QB'(w_ge) << B);
            end
        end
    end

    assign o_q = r_q[QB-1];

endmodule

FILE: sv/lav_norm.sv
// Pipelined three-lane vector normalizer of the look-at view matrix core.
// Block scaling, sum of squares, pipelined square root, three divider lanes.
// Depends on lav_pkg and lav_div.
module lav_norm import lav_pkg::*; #(
    parameter int FRAC = FRAC_BITS_DEF,
    parameter int SW   = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic signed [NRM_W-1:0] i_v [3],
    input  logic [SW-1:0]          i_side,
    output logic                   o_vld,
    output logic signed [FRAC+1:0] o_q [3],
    output logic [SW-1:0]          o_side
);

    localparam int SH_N = $clog2(NRM_W);
    localparam int QB   = FRAC + 1;
    localparam int QW   = FRAC + 2;
    localparam int NW   = NRM_MW + FRAC + 1;
    localparam int PW   = 2 * NRM_MW;

    // Magnitudes and signs.
    logic [NRM_W-1:0] r_s0_mag [3];
    logic [2:0]       r_s0_sgn;
    logic [SW-1:0]    r_s0_side;
    logic             r_s0_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (i_en) begin
            r_s0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s0_mag[i] <= i_v[i][NRM_W-1] ? NRM_W'(-i_v[i]) : NRM_W'(i_v[i]);
                r_s0_sgn[i] <= i_v[i][NRM_W-1];
            end
            r_s0_side <= i_side;
        end
    end

    // Common left shift: one power-of-two step per stage until the largest
    // magnitude has its top bit at the word's top.
    logic [NRM_W-1:0] r_sh_m    [SH_N][3];
    logic [2:0]       r_sh_sgn  [SH_N];
    logic [SW-1:0]    r_sh_side [SH_N];
    logic [SH_N-1:0]  r_sh_vld;

    for (genvar t = 0; t < SH_N; t++) begin : g_shift
        localparam int AMT = 1 << (SH_N - 1 - t);
        logic [NRM_W-1:0] w_m [3];
        logic [2:0]       w_sgn;
        logic [SW-1:0]    w_side;
        logic             w_vld;
        logic [NRM_W-1:0] w_or;
        logic             w_sh;

        if (t == 0) begin : g_first
            assign w_m    = r_s0_mag;
            assign w_sgn  = r_s0_sgn;
            assign w_side = r_s0_side;
            assign w_vld  = r_s0_vld;
        end else begin : g_next
            assign w_m    = r_sh_m[t-1];
            assign w_sgn  = r_sh_sgn[t-1];
            assign w_side = r_sh_side[t-1];
            assign w_vld  = r_sh_vld[t-1];
        end

        assign w_or = w_m[0] | w_m[1] | w_m[2];
        assign w_sh = ~|w_or[NRM_W-1 -: AMT];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sh_vld[t] <= 1'b0;
            end else if (i_en) begin
                r_sh_vld[t] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_sh_m[t][i] <= w_sh ? (w_m[i] << AMT) : w_m[i];
                end
                r_sh_sgn[t]  <= w_sgn;
                r_sh_side[t] <= w_side;
            end
        end
    end

    // Squares of the scaled magnitudes; an all-zero vector is flagged here.
    logic [NRM_MW-1:0] w_top [3];
    logic [NRM_MW-1:0] r_sq_m [3];
    logic [PW-1:0]     r_sq_p [3];
    logic              r_sq_zero;
    logic [2:0]        r_sq_sgn;
    logic [SW-1:0]     r_sq_side;
    logic              r_sq_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_top[i] = r_sh_m[SH_N-1][i][NRM_W-1 -: NRM_MW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else if (i_en) begin
            r_sq_vld <= r_sh_vld[SH_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq_m[i] <= w_top[i];
                r_sq_p[i] <= PW'(w_top[i]) * PW'(w_top[i]);
            end
            r_sq_zero <= ~(r_sh_m[SH_N-1][0][NRM_W-1] | r_sh_m[SH_N-1][1][NRM_W-1]
                         | r_sh_m[SH_N-1][2][NRM_W-1]);
            r_sq_sgn  <= r_sh_sgn[SH_N-1];
            r_sq_side <= r_sh_side[SH_N-1];
        end
    end

    // Sum of squares.
    logic [NRM_W-1:0]  r_sum;
    logic [NRM_MW-1:0] r_sum_m [3];
    logic              r_sum_zero;
    logic [2:0]        r_sum_sgn;
    logic [SW-1:0]     r_sum_side;
    logic              r_sum_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= 1'b0;
        end else if (i_en) begin
            r_sum_vld <= r_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum      <= NRM_W'(r_sq_p[0]) + NRM_W'(r_sq_p[1]) + NRM_W'(r_sq_p[2]);
            r_sum_m    <= r_sq_m;
            r_sum_zero <= r_sq_zero;
            r_sum_sgn  <= r_sq_sgn;
            r_sum_side <= r_sq_side;
        end
    end

    // Square root, one result bit per stage, most significant first.
    logic [NRM_W-1:0]  r_rt_rem  [NRM_RW];
    logic [NRM_RW-1:0] r_rt_q    [NRM_RW];
    logic [NRM_MW-1:0] r_rt_m    [NRM_RW][3];
    logic [NRM_RW-1:0] r_rt_zero;
    logic [2:0]        r_rt_sgn  [NRM_RW];
    logic [SW-1:0]     r_rt_side [NRM_RW];
    logic [NRM_RW-1:0] r_rt_vld;

    for (genvar t = 0; t < NRM_RW; t++) begin : g_sqrt
        localparam int B = NRM_RW - 1 - t;
        logic [NRM_W-1:0]  w_rem;
        logic [NRM_RW-1:0] w_q;
        logic [NRM_MW-1:0] w_m [3];
        logic              w_zero;
        logic [2:0]        w_sgn;
        logic [SW-1:0]     w_side;
        logic              w_vld;
        logic [NRM_W+1:0]  w_trial;
        logic              w_ge;

        if (t == 0) begin : g_first
            assign w_rem  = r_sum;
            assign w_q    = '0;
            assign w_m    = r_sum_m;
            assign w_zero = r_sum_zero;
            assign w_sgn  = r_sum_sgn;
            assign w_side = r_sum_side;
            assign w_vld  = r_sum_vld;
        end else begin : g_next
            assign w_rem  = r_rt_rem[t-1];
            assign w_q    = r_rt_q[t-1];
            assign w_m    = r_rt_m[t-1];
            assign w_zero = r_rt_zero[t-1];
            assign w_sgn  = r_rt_sgn[t-1];
            assign w_side = r_rt_side[t-1];
            assign w_vld  = r_rt_vld[t-1];
        end

        // (q + 2^B)^2 - q^2 = q * 2^(B+1) + 2^(2B)
        assign w_trial = ((NRM_W+2)'(w_q) << (B + 1)) + ((NRM_W+2)'(1) << (2 * B));
        assign w_ge    = (NRM_W+2)'(w_rem) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_vld[t] <= 1'b0;
            end else if (i_en) begin
                r_rt_vld[t] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rt_rem[t]  <= w_ge ? (w_rem - w_trial[NRM_W-1:0]) : w_rem;
                r_rt_q[t]    <= w_q | (NRM_RW'(w_ge) << B);
                r_rt_m[t]    <= w_m;
                r_rt_zero[t] <= w_zero;
                r_rt_sgn[t]  <= w_sgn;
                r_rt_side[t] <= w_side;
            end
        end
    end

    // Rounded numerators for the divider lanes.
    logic [NRM_RW-1:0] w_len;
    logic [NW-1:0]     r_dv_num [3];
    logic [NRM_RW-1:0] r_dv_len;
    logic              r_dv_zero;
    logic [2:0]        r_dv_sgn;
    logic [SW-1:0]     r_dv_side;
    logic              r_dv_vld;

    assign w_len = r_rt_q[NRM_RW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld <= 1'b0;
        end else if (i_en) begin
            r_dv_vld <= r_rt_vld[NRM_RW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dv_num[i] <= NW'({r_rt_m[NRM_RW-1][i], {FRAC{1'b0}}}) + NW'(w_len >> 1);
            end
            r_dv_len  <= w_len;
            r_dv_zero <= r_rt_zero[NRM_RW-1];
            r_dv_sgn  <= r_rt_sgn[NRM_RW-1];
            r_dv_side <= r_rt_side[NRM_RW-1];
        end
    end

    // Divider lanes, one per component.
    logic [QB-1:0] w_q [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        lav_div #(
            .NW (NW),
            .DW (NRM_RW),
            .QB (QB)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_num (r_dv_num[i]),
            .i_den (r_dv_len),
            .o_q   (w_q[i])
        );
    end

    // Sideband delay matching the divider lanes.
    logic [QB-1:0] r_dl_zero;
    logic [2:0]    r_dl_sgn  [QB];
    logic [SW-1:0] r_dl_side [QB];
    logic [QB-1:0] r_dl_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl_vld <= '0;
        end else if (i_en) begin
            r_dl_vld[0] <= r_dv_vld;
            for (int k = 1; k < QB; k++) begin
                r_dl_vld[k] <= r_dl_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dl_zero[0] <= r_dv_zero;
            r_dl_sgn[0]  <= r_dv_sgn;
            r_dl_side[0] <= r_dv_side;
            for (int k = 1; k < QB; k++) begin
                r_dl_zero[k] <= r_dl_zero[k-1];
                r_dl_sgn[k]  <= r_dl_sgn[k-1];
                r_dl_side[k] <= r_dl_side[k-1];
            end
        end
    end

    // Merge: clamp each quotient to one, restore signs, zero vector stays zero.
    localparam logic [QB-1:0] ONE_Q = QB'(1) << FRAC;

    logic [QB-1:0]        w_qc [3];
    logic signed [QW-1:0] r_o_q [3];
    logic [SW-1:0]        r_o_side;
    logic                 r_o_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_qc[i] = (w_q[i] > ONE_Q) ? ONE_Q : w_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_dl_vld[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_dl_zero[QB-1]) begin
                    r_o_q[i] <= '0;
                end else if (r_dl_sgn[QB-1][i]) begin
                    r_o_q[i] <= -QW'(w_qc[i]);
                end else begin
                    r_o_q[i] <= QW'(w_qc[i]);
                end
            end
            r_o_side <= r_dl_side[QB-1];
        end
    end

    assign o_vld  = r_o_vld;
    assign o_q    = r_o_q;
    assign o_side = r_o_side;

endmodule

FILE: sv/lav_cross.sv
// Pipelined cross product of the look-at view matrix core.
// Three component lanes: products registered, then differences registered.
// No package dependencies and no submodules.
module lav_cross #(
    parameter int AW = 32,
    parameter int BW = 18,
    parameter int SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic signed [AW-1:0]   i_a [3],
    input  logic signed [BW-1:0]   i_b [3],
    input  logic [SW-1:0]          i_side,
    output logic                   o_vld,
    output logic signed [AW+BW:0]  o_c [3],
    output logic [SW-1:0]          o_side
);

    localparam int PW = AW + BW;

    logic signed [PW-1:0] r_p0 [3];
    logic signed [PW-1:0] r_p1 [3];
    logic [SW-1:0]        r_p_side;
    logic                 r_p_vld;
    logic signed [PW:0]   r_c [3];
    logic [SW-1:0]        r_c_side;
    logic                 r_c_vld;

    // Product lanes: c[k] = a[k+1]*b[k+2] - a[k+2]*b[k+1].
    for (genvar k = 0; k < 3; k++) begin : g_lane
        localparam int J1 = (k + 1) % 3;
        localparam int J2 = (k + 2) % 3;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p0[k] <= i_a[J1] * i_b[J2];
                r_p1[k] <= i_a[J2] * i_b[J1];
                r_c[k]  <= (PW+1)'(r_p0[k]) - (PW+1)'(r_p1[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_vld;
            r_c_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_side <= i_side;
            r_c_side <= r_p_side;
        end
    end

    assign o_vld  = r_c_vld;
    assign o_c    = r_c;
    assign o_side = r_c_side;

endmodule

FILE: sv/look_at_view_matrix_core.sv
// Look-at view matrix core: accepts one transaction per cycle unless a finished
// result is held by a stalled consumer, which raises o_in_stall.
// The two vector normalizers set the latency: a 32-stage square root and a
// FRAC_BITS+1 stage divider per lane. The whole pipeline holds while a result waits.
// Synchronous active-low reset clears all valid bits; no result is pending after it.
module look_at_view_matrix_core import lav_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic signed [IN_W-1:0] i_eye_x,
    input  logic signed [IN_W-1:0] i_eye_y,
    input  logic signed [IN_W-1:0] i_eye_z,
    input  logic signed [IN_W-1:0] i_target_x,
    input  logic signed [IN_W-1:0] i_target_y,
    input  logic signed [IN_W-1:0] i_target_z,
    input  logic signed [IN_W-1:0] i_up_x,
    input  logic signed [IN_W-1:0] i_up_y,
    input  logic signed [IN_W-1:0] i_up_z,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [AX_W-1:0] o_right_x,
    output logic signed [AX_W-1:0] o_right_y,
    output logic signed [AX_W-1:0] o_right_z,
    output logic signed [AX_W-1:0] o_camup_x,
    output logic signed [AX_W-1:0] o_camup_y,
    output logic signed [AX_W-1:0] o_camup_z,
    output logic signed [AX_W-1:0] o_fwd_x,
    output logic signed [AX_W-1:0] o_fwd_y,
    output logic signed [AX_W-1:0] o_fwd_z,
    output logic signed [TR_W-1:0] o_trans_x,
    output logic signed [TR_W-1:0] o_trans_y,
    output logic signed [TR_W-1:0] o_trans_z
);

    localparam int FW   = FRAC_BITS + 2;
    localparam int CW   = IN_W + FW + 1;
    localparam int UW   = 2 * FW + 1;
    localparam int PW   = FW + IN_W;
    localparam int SUMW = PW + 2;
    localparam int TW   = PW + 3;
    localparam int XW   = FW + AX_W;
    localparam int S1   = 6 * IN_W;
    localparam int S2   = 3 * IN_W + 3 * FW;
    localparam int S3   = 3 * IN_W + 6 * FW;

    localparam logic [UW-1:0]        U_ONE   = UW'(1) << FRAC_BITS;
    localparam logic [UW-1:0]        U_HALF  = UW'(1) << (FRAC_BITS - 1);
    localparam logic [SUMW-1:0]      T_HALF  = SUMW'(1) << (FRAC_BITS - 1);
    localparam logic signed [XW-1:0] AX_HI_X = XW'(2**(AX_W-1) - 1);
    localparam logic signed [XW-1:0] AX_LO_X = -AX_HI_X - XW'(1);
    localparam logic signed [TW-1:0] TR_HI_X = TW'(2**(TR_W-1) - 1);
    localparam logic signed [TW-1:0] TR_LO_X = -TR_HI_X - TW'(1);

    // Saturate an axis entry to the output range.
    function automatic logic signed [AX_W-1:0] ax_sat(input logic signed [FW-1:0] v);
        logic signed [XW-1:0] w;
        w = XW'(v);
        if (w > AX_HI_X) begin
            return AX_W'(AX_HI_X);
        end else if (w < AX_LO_X) begin
            return AX_W'(AX_LO_X);
        end
        return AX_W'(w);
    endfunction

    // The whole pipeline advances unless a finished result is held.
    logic w_en;
    logic r_out_vld;

    assign w_en       = ~(r_out_vld & i_out_stall);
    assign o_in_stall = ~w_en;

    // Backward axis: normalize eye minus target.
    logic signed [IN_W:0]    w_d  [3];
    logic signed [NRM_W-1:0] w_dv [3];
    logic [S1-1:0]           w_side1_in;

    assign w_d[0] = (IN_W+1)'(i_eye_x) - (IN_W+1)'(i_target_x);
    assign w_d[1] = (IN_W+1)'(i_eye_y) - (IN_W+1)'(i_target_y);
    assign w_d[2] = (IN_W+1)'(i_eye_z) - (IN_W+1)'(i_target_z);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dv[i] = NRM_W'(w_d[i]);
        end
    end

    assign w_side1_in = {i_eye_x, i_eye_y, i_eye_z, i_up_x, i_up_y, i_up_z};

    logic                 w_vld1;
    logic signed [FW-1:0] w_f1 [3];
    logic [S1-1:0]        w_side1;

    lav_norm #(
        .FRAC (FRAC_BITS),
        .SW   (S1)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_v     (w_dv),
        .i_side  (w_side1_in),
        .o_vld   (w_vld1),
        .o_q     (w_f1),
        .o_side  (w_side1)
    );

    // Unpack eye and up from the first sideband.
    logic signed [IN_W-1:0] w_eye1 [3];
    logic signed [IN_W-1:0] w_up1  [3];
    logic [S2-1:0]          w_side2_in;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_eye1[k] = w_side1[(6-k)*IN_W-1 -: IN_W];
            w_up1[k]  = w_side1[(3-k)*IN_W-1 -: IN_W];
        end
    end

    assign w_side2_in = {w_eye1[0], w_eye1[1], w_eye1[2], w_f1[0], w_f1[1], w_f1[2]};

    // Unnormalized right axis: up cross backward, exact.
    logic                 w_vld2;
    logic signed [CW-1:0] w_c [3];
    logic [S2-1:0]        w_side2;

    lav_cross #(
        .AW (IN_W),
        .BW (FW),
        .SW (S2)
    ) u_cross_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld1),
        .i_a     (w_up1),
        .i_b     (w_f1),
        .i_side  (w_side2_in),
        .o_vld   (w_vld2),
        .o_c     (w_c),
        .o_side  (w_side2)
    );

    // Right axis: normalize the cross product.
    logic signed [NRM_W-1:0] w_cv [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_cv[i] = NRM_W'(w_c[i]);
        end
    end

    logic                 w_vld3;
    logic signed [FW-1:0] w_r3 [3];
    logic [S2-1:0]        w_side3;

    lav_norm #(
        .FRAC (FRAC_BITS),
        .SW   (S2)
    ) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld2),
        .i_v     (w_cv),
        .i_side  (w_side2),
        .o_vld   (w_vld3),
        .o_q     (w_r3),
        .o_side  (w_side3)
    );

    // Unpack backward axis and pass eye on.
    logic signed [FW-1:0] w_f3 [3];
    logic [S3-1:0]        w_side4_in;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_f3[k] = w_side3[(3-k)*FW-1 -: FW];
        end
    end

    assign w_side4_in = {w_side3, w_r3[0], w_r3[1], w_r3[2]};

    // Camera up axis before rounding: backward cross right.
    logic                 w_vld4;
    logic signed [UW-1:0] w_ud [3];
    logic [S3-1:0]        w_side4;

    lav_cross #(
        .AW (FW),
        .BW (FW),
        .SW (S3)
    ) u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld3),
        .i_a     (w_f3),
        .i_b     (w_r3),
        .i_side  (w_side4_in),
        .o_vld   (w_vld4),
        .o_c     (w_ud),
        .o_side  (w_side4)
    );

    // Round camera up to nearest, ties away from zero, and clamp to one.
    logic [UW-1:0]          w_um [3];
    logic [UW-1:0]          w_ur [3];
    logic signed [IN_W-1:0] w_eye4 [3];
    logic signed [FW-1:0]   r_u_ax  [3][3];
    logic signed [IN_W-1:0] r_u_eye [3];
    logic                   r_u_vld;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_um[k]   = w_ud[k][UW-1] ? UW'(-w_ud[k]) : UW'(w_ud[k]);
            w_ur[k]   = (w_um[k] + U_HALF) >> FRAC_BITS;
            w_ur[k]   = (w_ur[k] > U_ONE) ? U_ONE : w_ur[k];
            w_eye4[k] = w_side4[S3-1-k*IN_W -: IN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_vld <= 1'b0;
        end else if (w_en) begin
            r_u_vld <= w_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_u_ax[0][k] <= w_side4[(3-k)*FW-1 -: FW];
                r_u_ax[1][k] <= w_ud[k][UW-1] ? -FW'(w_ur[k]) : FW'(w_ur[k]);
                r_u_ax[2][k] <= w_side4[(6-k)*FW-1 -: FW];
                r_u_eye[k]   <= w_eye4[k];
            end
        end
    end

    // Dot-product lanes: one product per axis and component.
    logic signed [PW-1:0] r_p_pr [3][3];
    logic signed [FW-1:0] r_p_ax [3][3];
    logic                 r_p_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_en) begin
            r_p_vld <= r_u_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 3; k++) begin
                    r_p_pr[a][k] <= r_u_ax[a][k] * r_u_eye[k];
                end
            end
            r_p_ax <= r_u_ax;
        end
    end

    // Merge the lanes: sum each dot product.
    logic signed [SUMW-1:0] r_s_sum [3];
    logic signed [FW-1:0]   r_s_ax  [3][3];
    logic                   r_s_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (w_en) begin
            r_s_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_s_sum[a] <= SUMW'(r_p_pr[a][0]) + SUMW'(r_p_pr[a][1])
                            + SUMW'(r_p_pr[a][2]);
            end
            r_s_ax <= r_p_ax;
        end
    end

    // Round, negate and saturate the translations; saturate the axes.
    logic [SUMW-1:0]        w_tm [3];
    logic [SUMW-1:0]        w_tr [3];
    logic signed [TW-1:0]   w_tv [3];
    logic signed [TR_W-1:0] w_ts [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_tm[a] = r_s_sum[a][SUMW-1] ? SUMW'(-r_s_sum[a]) : SUMW'(r_s_sum[a]);
            w_tr[a] = (w_tm[a] + T_HALF) >> FRAC_BITS;
            w_tv[a] = r_s_sum[a][SUMW-1] ? $signed({1'b0, w_tr[a]})
                                         : -$signed({1'b0, w_tr[a]});
            if (w_tv[a] > TR_HI_X) begin
                w_ts[a] = TR_W'(TR_HI_X);
            end else if (w_tv[a] < TR_LO_X) begin
                w_ts[a] = TR_W'(TR_LO_X);
            end else begin
                w_ts[a] = TR_W'(w_tv[a]);
            end
        end
    end

    // Output register; holds a valid result while the consumer stalls.
    logic signed [AX_W-1:0] r_out_ax [3][3];
    logic signed [TR_W-1:0] r_out_tr [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 3; k++) begin
                    r_out_ax[a][k] <= ax_sat(r_s_ax[a][k]);
                end
            end
            r_out_tr <= w_ts;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_right_x   = r_out_ax[0][0];
    assign o_right_y   = r_out_ax[0][1];
    assign o_right_z   = r_out_ax[0][2];
    assign o_camup_x   = r_out_ax[1][0];
    assign o_camup_y   = r_out_ax[1][1];
    assign o_camup_z   = r_out_ax[1][2];
    assign o_fwd_x     = r_out_ax[2][0];
    assign o_fwd_y     = r_out_ax[2][1];
    assign o_fwd_z     = r_out_ax[2][2];
    assign o_trans_x   = r_out_tr[0];
    assign o_trans_y   = r_out_tr[1];
    assign o_trans_z   = r_out_tr[2];

endmodule
